/* rtl/core/fskhc_pkg.sv */
// Shared types and constants for the FSK half-cycle pulse generator.
// Used by the channel interfaces and the top level; depends on nothing.
package fskhc_pkg;

	localparam int HALF_W       = 20;  // half-cycle register width, fixed point
	localparam int ACTION_W     = 2;
	localparam int CYCLES_W     = 5;
	localparam int GAP_W        = 32;
	localparam int PULSE_W      = 32;
	localparam int PULSE_CNT_W  = 6;   // holds twice the largest cycle count
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = HALF_W;

	localparam int FRACTION_BITS_DEFAULT = 8;
	localparam int MAX_CYCLES_DEFAULT    = 31;

	localparam logic [HALF_W-1:0] LOW_HALF_RESET  = HALF_W'(4704);
	localparam logic [HALF_W-1:0] HIGH_HALF_RESET = HALF_W'(2352);
	localparam logic              INIT_LEVEL_RESET = 1'b0;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOW  = 2'd0,
		ACT_HIGH = 2'd1,
		ACT_GAP  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_HALF   = 2'd0,
		REG_HIGH_HALF  = 2'd1,
		REG_INIT_LEVEL = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_GAP_LEAD,
		ST_GAP_BODY
	} state_t;

endpackage

/* rtl/core/fskhc_cmd_if.sv */
// Command channel: one item asks for a tone run or a gap.
// Depends on fskhc_pkg for the field widths.
interface fskhc_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [fskhc_pkg::ACTION_W-1:0]       action;
	logic [fskhc_pkg::CYCLES_W-1:0]       cycle_count;
	logic [fskhc_pkg::GAP_W-1:0]          gap_samples;

	modport source (output valid, action, cycle_count, gap_samples, input ready);
	modport sink   (input valid, action, cycle_count, gap_samples, output ready);
endinterface

/* rtl/core/fskhc_pulse_if.sv */
// Pulse channel: one item is one half-cycle pulse with its level and flags.
// Depends on fskhc_pkg for the field widths.
interface fskhc_pulse_if;
	logic                             valid;
	logic                             ready;
	logic [fskhc_pkg::PULSE_W-1:0]    pulse_length;
	logic                             pulse_level;
	logic                             zero_length_error;
	logic                             last_pulse;

	modport source (output valid, pulse_length, pulse_level, zero_length_error, last_pulse,
		input ready);
	modport sink   (input valid, pulse_length, pulse_level, zero_length_error, last_pulse,
		output ready);
endinterface

/* rtl/core/fskhc_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on fskhc_pkg for the field widths.
interface fskhc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [fskhc_pkg::CFG_IDX_W-1:0]     index;
	logic [fskhc_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/fsk_half_cycle_pulse_generator_top.sv */
// Top level of the FSK half-cycle pulse generator: sequencer, position
// accumulator and output register. Depends on fskhc_pkg and the three channel interfaces.
//
// Usage. A command item on cmd asks for a run of square-wave cycles at the
// low or high tone, or for a gap. A run of n tone periods yields 2n half-cycle
// pulses on the pulse channel; their lengths are the differences of rounded
// cumulative positions of the configured half-cycle length, which keeps the
// average period exact. A gap yields a one-sample pulse when the level is
// low, then one pulse of the gap length. Each unflagged pulse toggles the level; a
// computed length of zero is reported with zero_length_error and ends the run.
// The cfg channel writes the two half-cycle lengths and the initial level;
// it is always ready and writing the initial level also presets the level.
//
// Timing. The command is taken when the sequencer is idle. The sequencer
// registers its new state, and the first pulse is then loaded into the output
// register; one pulse follows per clock while the receiver takes them. No new
// command is taken until the last pulse of the current one is produced. The
// rate is set by the single position adder and rounding subtractor, used once
// per pulse. Commands that yield nothing are taken and dropped while idle.
// When the receiver stalls, the output register holds its pulse and the
// sequencer waits. Reset restores the register defaults, a low level, an
// idle sequencer and an empty output register.
module fsk_half_cycle_pulse_generator_top #(
	parameter int FRACTION_BITS = fskhc_pkg::FRACTION_BITS_DEFAULT,
	parameter int MAX_CYCLES    = fskhc_pkg::MAX_CYCLES_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fskhc_cmd_if.sink             cmd,
	fskhc_pulse_if.source         pulse,
	fskhc_cfg_if.sink             cfg
);

	localparam int HW  = fskhc_pkg::HALF_W;
	localparam int CW  = fskhc_pkg::PULSE_CNT_W;
	localparam int PW  = HW + CW;                 // position i*h, i below 2^CW
	localparam int RW  = PW + 1 - FRACTION_BITS;  // rounded position
	localparam logic [PW:0] ROUND_HALF = (PW+1)'(1) << (FRACTION_BITS - 1);

	// Configuration registers.
	logic [HW-1:0] low_half_q;
	logic [HW-1:0] high_half_q;
	logic          init_level_q;

	// Sequencer and datapath state.
	fskhc_pkg::state_t state_q, state_d;
	logic          level_q, level_d;
	logic [HW-1:0] half_q;
	logic [PW-1:0] pos_q;
	logic [RW-1:0] prev_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pulses_q;
	logic [fskhc_pkg::GAP_W-1:0] gap_q;

	// Output register.
	logic                        out_valid_q;
	logic [fskhc_pkg::PULSE_W-1:0] out_len_q;
	logic                        out_level_q;
	logic                        out_err_q;
	logic                        out_last_q;

	// Combinational controls.
	logic                          cmd_take;
	logic                          slot_free;
	logic                          emit;
	logic [fskhc_pkg::PULSE_W-1:0] emit_len;
	logic                          emit_level;
	logic                          emit_err;
	logic                          emit_last;
	logic                          start_run;
	logic                          advance;
	logic [PW:0]                   rounded_sum;
	logic [RW-1:0]                 rounded;
	logic [RW-1:0]                 step_len;
	logic [fskhc_pkg::CYCLES_W-1:0] cycles_sat;
	logic                          cfg_take;

	assign cmd.ready  = (state_q == fskhc_pkg::ST_IDLE);
	assign cmd_take   = cmd.valid && cmd.ready;
	assign cfg.ready  = 1'b1;
	assign cfg_take   = cfg.valid;
	assign slot_free  = !out_valid_q || pulse.ready;

	assign pulse.valid             = out_valid_q;
	assign pulse.pulse_length      = out_len_q;
	assign pulse.pulse_level       = out_level_q;
	assign pulse.zero_length_error = out_err_q;
	assign pulse.last_pulse        = out_last_q;

	// The shared unit: round the current position and take the difference
	// to the previous rounded position.
	assign rounded_sum = (PW+1)'(pos_q) + ROUND_HALF;
	assign rounded     = rounded_sum[PW:FRACTION_BITS];
	assign step_len    = rounded - prev_q;

	assign cycles_sat = (cmd.cycle_count > fskhc_pkg::CYCLES_W'(MAX_CYCLES))
		? fskhc_pkg::CYCLES_W'(MAX_CYCLES) : cmd.cycle_count;

	always_comb begin
		state_d    = state_q;
		level_d    = level_q;
		emit       = 1'b0;
		emit_len   = '0;
		emit_level = level_q;
		emit_err   = 1'b0;
		emit_last  = 1'b0;
		start_run  = 1'b0;
		advance    = 1'b0;
		case (state_q)
			fskhc_pkg::ST_IDLE: begin
				if (cmd_take) begin
					case (cmd.action)
						fskhc_pkg::ACT_LOW, fskhc_pkg::ACT_HIGH: begin
							if (cycles_sat != '0) begin
								start_run = 1'b1;
								state_d   = fskhc_pkg::ST_RUN;
							end
						end
						fskhc_pkg::ACT_GAP: begin
							if (cmd.gap_samples != '0) begin
								state_d = level_q ? fskhc_pkg::ST_GAP_BODY
									: fskhc_pkg::ST_GAP_LEAD;
							end
						end
						default: ;
					endcase
				end
			end
			fskhc_pkg::ST_RUN: begin
				if (slot_free) begin
					emit = 1'b1;
					if (step_len == '0) begin
						emit_err  = 1'b1;
						emit_last = 1'b1;
						state_d   = fskhc_pkg::ST_IDLE;
					end else begin
						emit_len   = fskhc_pkg::PULSE_W'(step_len);
						level_d    = !level_q;
						emit_level = !level_q;
						advance    = (cnt_q != '0);
						if (cnt_q + CW'(1) == pulses_q) begin
							emit_last = 1'b1;
							state_d   = fskhc_pkg::ST_IDLE;
						end
					end
				end
			end
			fskhc_pkg::ST_GAP_LEAD: begin
				if (slot_free) begin
					emit       = 1'b1;
					emit_len   = fskhc_pkg::PULSE_W'(1);
					level_d    = 1'b1;
					emit_level = 1'b1;
					state_d    = fskhc_pkg::ST_GAP_BODY;
				end
			end
			fskhc_pkg::ST_GAP_BODY: begin
				if (slot_free) begin
					emit       = 1'b1;
					emit_len   = gap_q;
					level_d    = !level_q;
					emit_level = !level_q;
					emit_last  = 1'b1;
					state_d    = fskhc_pkg::ST_IDLE;
				end
			end
			default: state_d = fskhc_pkg::ST_IDLE;
		endcase
		// A level preset is to be written only while idle; the block does not enforce it.
		if (cfg_take && cfg.index == fskhc_pkg::REG_INIT_LEVEL) begin
			level_d = cfg.data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fskhc_pkg::ST_IDLE;
			level_q <= fskhc_pkg::INIT_LEVEL_RESET;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_half_q   <= fskhc_pkg::LOW_HALF_RESET;
			high_half_q  <= fskhc_pkg::HIGH_HALF_RESET;
			init_level_q <= fskhc_pkg::INIT_LEVEL_RESET;
		end else if (cfg_take) begin
			case (cfg.index)
				fskhc_pkg::REG_LOW_HALF:   low_half_q   <= cfg.data;
				fskhc_pkg::REG_HIGH_HALF:  high_half_q  <= cfg.data;
				fskhc_pkg::REG_INIT_LEVEL: init_level_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Run datapath. The first two pulses of a run both use the first rounded
	// position, so the accumulator only moves from the second pulse on.
	always_ff @(posedge clk) begin
		if (start_run) begin
			half_q   <= (cmd.action == fskhc_pkg::ACT_HIGH) ? high_half_q : low_half_q;
			pos_q    <= PW'((cmd.action == fskhc_pkg::ACT_HIGH) ? high_half_q : low_half_q);
			prev_q   <= '0;
			cnt_q    <= '0;
			pulses_q <= {cycles_sat, 1'b0};
		end else if (emit && state_q == fskhc_pkg::ST_RUN) begin
			cnt_q <= cnt_q + CW'(1);
			if (advance) begin
				prev_q <= rounded;
				pos_q  <= pos_q + PW'(half_q);
			end
		end
		if (cmd_take) begin
			gap_q <= cmd.gap_samples;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pulse.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_len_q   <= emit_len;
			out_level_q <= emit_level;
			out_err_q   <= emit_err;
			out_last_q  <= emit_last;
		end
	end

	// The pulse count never reaches its end while a run is in progress.
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fskhc_pkg::ST_RUN |-> cnt_q < pulses_q)
		else $error("run pulse count out of range");

	// A flagged pulse is empty and always closes its command.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q |-> out_last_q && out_len_q == '0)
		else $error("zero-length pulse not closing the command");

	// Producing the final pulse of a command returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> state_q == fskhc_pkg::ST_IDLE)
		else $error("sequencer busy after final pulse");

	// A low-tone run command with cycles blocks the command channel next cycle.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take && cmd.action == fskhc_pkg::ACT_LOW && cmd.cycle_count != '0
		|=> !cmd.ready)
		else $error("run command did not start the sequencer");

	// A normal pulse carries the level it toggled to.
	a_level_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !emit_err |=> out_level_q == level_q)
		else $error("pulse level differs from stored level");

endmodule

/* tb/fsk_half_cycle_pulse_generator_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for fsk_half_cycle_pulse_generator_top: directed table, random runs.
// Depends on fskhc_pkg, the three channel interfaces and the top level under test.
module fsk_half_cycle_pulse_generator_top_test;

	localparam int FRAC         = fskhc_pkg::FRACTION_BITS_DEFAULT;
	localparam int MAX_CYC      = fskhc_pkg::MAX_CYCLES_DEFAULT;
	localparam int SETTLE       = 4;       // quiet cycles before a register write
	localparam int TAIL         = 16;      // cycles watched for stray pulses at the end
	localparam int HOLD_CYCLES  = 400;     // long receiver stall
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 48;      // items per random phase that yield pulses
	localparam int LIMIT        = 600000;

	// One pulse as the block reports it.
	typedef struct packed {
		logic [fskhc_pkg::PULSE_W-1:0] len;
		logic                          level;
		logic                          err;
		logic                          last;
	} pulse_t;

	// One row of the directed table: a register write, or a command. A command
	// row either carries its pulses typed in, or leaves them to the predictor.
	typedef struct packed {
		bit                               is_reg;
		fskhc_pkg::reg_idx_t              reg_sel;
		logic [fskhc_pkg::CFG_DATA_W-1:0] reg_data;
		fskhc_pkg::action_t               act;
		logic [fskhc_pkg::CYCLES_W-1:0]   cycles;
		logic [fskhc_pkg::GAP_W-1:0]      gap;
		bit                               typed;
		logic [1:0]                       n_typed;
		pulse_t                           first;
		pulse_t                           second;
	} step_t;

	logic clk;
	logic arst_n;

	fskhc_cmd_if   cmd_bus ();
	fskhc_pulse_if pulse_bus ();
	fskhc_cfg_if   cfg_bus ();

	fsk_half_cycle_pulse_generator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.pulse  (pulse_bus),
		.cfg    (cfg_bus)
	);

	// Shadow copy of the registers and of the output level.
	logic [fskhc_pkg::HALF_W-1:0] low_half   = fskhc_pkg::LOW_HALF_RESET;
	logic [fskhc_pkg::HALF_W-1:0] high_half  = fskhc_pkg::HIGH_HALF_RESET;
	logic                         tone_level = fskhc_pkg::INIT_LEVEL_RESET;

	// Pulses still owed by the block, oldest first.
	pulse_t pending_pulses[$];

	int unsigned mismatches = 0;
	int unsigned rand_items = 0;
	int unsigned elapsed    = 0;
	bit          hold       = 1'b0;   // receiver forced to stall
	bit          quiet      = 1'b0;   // both sides run without idle cycles

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic pulse_t pulse_of(input logic [fskhc_pkg::PULSE_W-1:0] len,
		input logic level, input logic err, input logic last);
		pulse_t p;
		p.len   = len;
		p.level = level;
		p.err   = err;
		p.last  = last;
		return p;
	endfunction

	// Appends one pulse to the ones the block still owes.
	function automatic void owe_pulse(input pulse_t p);
		pending_pulses.insert(pending_pulses.size(), p);
	endfunction

	function automatic step_t cmd_step(input fskhc_pkg::action_t act,
		input logic [fskhc_pkg::CYCLES_W-1:0] cyc, input logic [fskhc_pkg::GAP_W-1:0] gap);
		step_t s;
		s = '0;
		s.act    = act;
		s.cycles = cyc;
		s.gap    = gap;
		return s;
	endfunction

	function automatic step_t known_step(input fskhc_pkg::action_t act,
		input logic [fskhc_pkg::CYCLES_W-1:0] cyc, input logic [fskhc_pkg::GAP_W-1:0] gap,
		input logic [1:0] n, input pulse_t p0, input pulse_t p1);
		step_t s;
		s = cmd_step(act, cyc, gap);
		s.typed   = 1'b1;
		s.n_typed = n;
		s.first   = p0;
		s.second  = p1;
		return s;
	endfunction

	function automatic step_t reg_step(input fskhc_pkg::reg_idx_t idx,
		input logic [fskhc_pkg::CFG_DATA_W-1:0] data);
		step_t s;
		s = '0;
		s.is_reg   = 1'b1;
		s.reg_sel  = idx;
		s.reg_data = data;
		return s;
	endfunction

	// Round half up from fixed point to whole samples.
	function automatic logic [63:0] round_samples(input logic [63:0] pos);
		return (pos + (64'd1 << (FRAC - 1))) >> FRAC;
	endfunction

	// Works out the pulses one command yields and queues them, moving the level along.
	// A run's pulse k is the step between rounded positions (k-1)*h and k*h, except
	// that the first two pulses both take the rounded h.
	function automatic void predict_pulses(input fskhc_pkg::action_t act,
		input logic [fskhc_pkg::CYCLES_W-1:0] cyc, input logic [fskhc_pkg::GAP_W-1:0] gap);
		logic [63:0] h;
		logic [63:0] len;
		int unsigned runs;
		int unsigned halves;
		if (act == fskhc_pkg::ACT_GAP) begin
			if (gap != '0) begin
				// A low line first gets a one-sample high pulse, then the gap itself.
				if (!tone_level) begin
					tone_level = 1'b1;
					owe_pulse(pulse_of(32'd1, 1'b1, 1'b0, 1'b0));
				end
				tone_level = ~tone_level;
				owe_pulse(pulse_of(gap, tone_level, 1'b0, 1'b1));
			end
		end else if (act == fskhc_pkg::ACT_LOW || act == fskhc_pkg::ACT_HIGH) begin
			h      = 64'((act == fskhc_pkg::ACT_HIGH) ? high_half : low_half);
			runs   = (cyc > MAX_CYC) ? MAX_CYC : cyc;
			halves = 2 * runs;
			for (int unsigned i = 0; i < halves; i++) begin
				if (i == 0)
					len = round_samples(h);
				else
					len = round_samples(i * h) - round_samples((i - 1) * h);
				if (len == 0) begin
					// A zero step ends the run and leaves the level alone.
					owe_pulse(pulse_of('0, tone_level, 1'b1, 1'b1));
					return;
				end
				tone_level = ~tone_level;
				owe_pulse(pulse_of(len[fskhc_pkg::PULSE_W-1:0], tone_level, 1'b0,
					i + 1 == halves));
			end
		end
	endfunction

	// Half-cycle length for a random phase: mostly tape-like values, some full-range
	// values and some corner values around the rounding edges.
	function automatic logic [fskhc_pkg::HALF_W-1:0] pick_half();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 6))
				0: return '0;
				1: return fskhc_pkg::HALF_W'(1);
				2: return fskhc_pkg::HALF_W'(127);
				3: return fskhc_pkg::HALF_W'(128);
				4: return fskhc_pkg::HALF_W'(255);
				5: return fskhc_pkg::HALF_W'(256);
				default: return '1;
			endcase
		end
		if (r == 1)
			return fskhc_pkg::HALF_W'($urandom_range(0, 20'hFFFFF));
		return fskhc_pkg::HALF_W'($urandom_range(1024, 12000));
	endfunction

	task automatic report_bad(input string what, input pulse_t want, input pulse_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected len=%0d level=%0b err=%0b last=%0b, %s",
				$realtime, what, want.len, want.level, want.err, want.last,
				$sformatf("got len=%0d level=%0b err=%0b last=%0b",
					got.len, got.level, got.err, got.last));
	endtask

	// Drops the command valid and waits until every owed pulse has come out, then
	// a few more cycles so that a command which yields nothing is surely gone too.
	task automatic drain();
		cmd_bus.valid <= 1'b0;
		while (pending_pulses.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register writes happen only with the block idle, so the shadow copy can be
	// updated as soon as the write is taken.
	task automatic write_reg(input fskhc_pkg::reg_idx_t idx,
		input logic [fskhc_pkg::CFG_DATA_W-1:0] data);
		drain();
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		case (idx)
			fskhc_pkg::REG_LOW_HALF:   low_half  = data;
			fskhc_pkg::REG_HIGH_HALF:  high_half = data;
			fskhc_pkg::REG_INIT_LEVEL: tone_level = data[0];
			default: ;
		endcase
	endtask

	// Offers one command, with random idle cycles ahead of it unless the quiet
	// stretch is on. Valid stays high on return so back-to-back items need no
	// second assignment in the same step.
	task automatic offer_cmd(input fskhc_pkg::action_t act,
		input logic [fskhc_pkg::CYCLES_W-1:0] cyc, input logic [fskhc_pkg::GAP_W-1:0] gap);
		while (!quiet && $urandom_range(0, 99) < 28) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid       <= 1'b1;
		cmd_bus.action      <= act;
		cmd_bus.cycle_count <= cyc;
		cmd_bus.gap_samples <= gap;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
	endtask

	// Receiver: stalls at random about 28 percent of the time, never while quiet, and
	// always while the long hold-off is on.
	always @(posedge clk)
		pulse_bus.ready <= !hold && (quiet || $urandom_range(0, 99) >= 28);

	// One long receiver stall in the middle of a random phase. The sender keeps
	// offering items, so the output register fills and the command input backs up.
	initial begin : receiver_hold
		wait (rand_items >= 120);
		hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold <= 1'b0;
	end

	// Every pulse taken is checked against the oldest one owed.
	always @(posedge clk) begin : check_pulses
		pulse_t got;
		pulse_t want;
		if (arst_n === 1'b1 && pulse_bus.valid === 1'b1 && pulse_bus.ready === 1'b1) begin
			got = pulse_of(pulse_bus.pulse_length, pulse_bus.pulse_level,
				pulse_bus.zero_length_error, pulse_bus.last_pulse);
			if (pending_pulses.size() == 0) begin
				report_bad("pulse with none owed", 'x, got);
			end else begin
				want = pending_pulses.pop_front();
				if (got.len !== want.len || got.level !== want.level ||
					got.err !== want.err || got.last !== want.last)
					report_bad("pulse mismatch", want, got);
			end
		end
	end

	// Hard stop for a hung block.
	always @(posedge clk) begin
		elapsed <= elapsed + 1;
		if (elapsed == LIMIT) begin
			$display("fsk_half_cycle_pulse_generator_top verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		step_t   plan[$];
		step_t   s;
		int      base;
		int      counted;
		fskhc_pkg::action_t act;
		logic [fskhc_pkg::CYCLES_W-1:0] cyc;
		logic [fskhc_pkg::GAP_W-1:0]    gap;
		int unsigned r;

		arst_n              <= 1'b0;
		cmd_bus.valid       <= 1'b0;
		cmd_bus.action      <= fskhc_pkg::ACT_LOW;
		cmd_bus.cycle_count <= '0;
		cmd_bus.gap_samples <= '0;
		cfg_bus.valid       <= 1'b0;
		cfg_bus.index       <= fskhc_pkg::REG_LOW_HALF;
		cfg_bus.data        <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table. Reset values hold at first: low tone 18.375 samples,
		// high tone 9.1875 samples, line low. Typed rows are the ones whose
		// pulses follow straight from the rules; the rest go to the predictor.
		plan = '{
			// Commands that yield nothing: empty gap, unused action, empty run.
			known_step(fskhc_pkg::ACT_GAP,  5'd0,  32'd0,         2'd0, '0, '0),
			known_step(fskhc_pkg::ACT_NONE, 5'd31, 32'hFFFF_FFFF, 2'd0, '0, '0),
			known_step(fskhc_pkg::ACT_LOW,  5'd0,  32'hFFFF_FFFF, 2'd0, '0, '0),
			// Gaps from a low line get the one-sample lead pulse.
			known_step(fskhc_pkg::ACT_GAP, 5'd0, 32'd1, 2'd2,
				pulse_of(32'd1, 1'b1, 1'b0, 1'b0), pulse_of(32'd1, 1'b0, 1'b0, 1'b1)),
			known_step(fskhc_pkg::ACT_GAP, 5'd31, 32'hFFFF_FFFF, 2'd2,
				pulse_of(32'd1, 1'b1, 1'b0, 1'b0),
				pulse_of(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1)),
			// Tone runs, shortest and longest, with alternating bit patterns.
			cmd_step(fskhc_pkg::ACT_LOW,  5'd1,     32'd0),
			cmd_step(fskhc_pkg::ACT_HIGH, 5'd31,    32'd0),
			cmd_step(fskhc_pkg::ACT_LOW,  5'd31,    32'd0),
			cmd_step(fskhc_pkg::ACT_HIGH, 5'b10101, 32'h5555_5555),
			cmd_step(fskhc_pkg::ACT_LOW,  5'b01010, 32'hAAAA_AAAA),
			// A zero half-cycle gives a flagged empty pulse straight away.
			reg_step(fskhc_pkg::REG_LOW_HALF, 20'd0),
			known_step(fskhc_pkg::ACT_LOW, 5'd3, 32'd0, 2'd1,
				pulse_of(32'd0, 1'b0, 1'b1, 1'b1), '0),
			// One 256th of a sample still rounds to nothing.
			reg_step(fskhc_pkg::REG_HIGH_HALF, 20'd1),
			known_step(fskhc_pkg::ACT_HIGH, 5'd31, 32'd0, 2'd1,
				pulse_of(32'd0, 1'b0, 1'b1, 1'b1), '0),
			// Level preset: a gap from a high line has no lead pulse.
			reg_step(fskhc_pkg::REG_INIT_LEVEL, 20'd1),
			known_step(fskhc_pkg::ACT_GAP, 5'd0, 32'd5, 2'd1,
				pulse_of(32'd5, 1'b0, 1'b0, 1'b1), '0),
			reg_step(fskhc_pkg::REG_INIT_LEVEL, 20'd1),
			// A write to the unused index must leave the high tone at one.
			reg_step(fskhc_pkg::REG_UNUSED, 20'hFFFFF),
			known_step(fskhc_pkg::ACT_HIGH, 5'd2, 32'd0, 2'd1,
				pulse_of(32'd0, 1'b1, 1'b1, 1'b1), '0),
			known_step(fskhc_pkg::ACT_GAP, 5'd0, 32'h8000_0000, 2'd1,
				pulse_of(32'h8000_0000, 1'b0, 1'b0, 1'b1), '0),
			// Exactly half a sample: two one-sample pulses, then a zero step.
			reg_step(fskhc_pkg::REG_LOW_HALF, 20'd128),
			cmd_step(fskhc_pkg::ACT_LOW, 5'd4, 32'd0),
			reg_step(fskhc_pkg::REG_HIGH_HALF, 20'hFFFFF),
			cmd_step(fskhc_pkg::ACT_HIGH, 5'd31, 32'd0),
			// Just under half a sample: nothing comes of the first pulse.
			reg_step(fskhc_pkg::REG_LOW_HALF, 20'd127),
			known_step(fskhc_pkg::ACT_LOW, 5'd1, 32'd0, 2'd1,
				pulse_of(32'd0, 1'b0, 1'b1, 1'b1), '0),
			reg_step(fskhc_pkg::REG_LOW_HALF, 20'hFFFFF),
			reg_step(fskhc_pkg::REG_INIT_LEVEL, 20'd0),
			cmd_step(fskhc_pkg::ACT_LOW, 5'd31, 32'd0)
		};

		foreach (plan[i]) begin
			s = plan[i];
			if (s.is_reg) begin
				write_reg(s.reg_sel, s.reg_data);
			end else begin
				// The predictor still runs on typed rows to keep the level in step,
				// but the typed pulses replace what it queued.
				base = pending_pulses.size();
				predict_pulses(s.act, s.cycles, s.gap);
				if (s.typed) begin
					while (pending_pulses.size() > base)
						void'(pending_pulses.pop_back());
					if (s.n_typed > 0)
						owe_pulse(s.first);
					if (s.n_typed > 1)
						owe_pulse(s.second);
				end
				offer_cmd(s.act, s.cycles, s.gap);
			end
		end

		// Random phases, each under fresh register settings. Phase three runs with
		// no idle cycles on either side; the long receiver stall lands in phase two.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(fskhc_pkg::REG_LOW_HALF, pick_half());
			write_reg(fskhc_pkg::REG_HIGH_HALF, pick_half());
			if ($urandom_range(0, 3) == 0)
				write_reg(fskhc_pkg::REG_UNUSED,
					fskhc_pkg::CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
			write_reg(fskhc_pkg::REG_INIT_LEVEL,
				fskhc_pkg::CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
			quiet <= (ph == 3);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 42)
					act = fskhc_pkg::ACT_LOW;
				else if (r < 84)
					act = fskhc_pkg::ACT_HIGH;
				else if (r < 96)
					act = fskhc_pkg::ACT_GAP;
				else
					act = fskhc_pkg::ACT_NONE;
				cyc = ($urandom_range(0, 11) == 0) ? '0
					: fskhc_pkg::CYCLES_W'($urandom_range(1, 31));
				case ($urandom_range(0, 9))
					0:       gap = '0;
					1:       gap = '1;
					2, 3:    gap = $urandom;
					default: gap = $urandom_range(1, 2000);
				endcase
				predict_pulses(act, cyc, gap);
				offer_cmd(act, cyc, gap);
				// Items the block drops without a pulse do not count toward the phase.
				if ((act == fskhc_pkg::ACT_GAP && gap != '0) ||
					((act == fskhc_pkg::ACT_LOW || act == fskhc_pkg::ACT_HIGH) &&
					cyc != '0)) begin
					counted++;
					rand_items++;
				end
			end
		end

		drain();
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0)
			$display("fsk_half_cycle_pulse_generator_top verification clean");
		else
			$display("fsk_half_cycle_pulse_generator_top verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/fskhc_pkg.sv
rtl/core/fskhc_cmd_if.sv
rtl/core/fskhc_pulse_if.sv
rtl/core/fskhc_cfg_if.sv
rtl/core/fsk_half_cycle_pulse_generator_top.sv
tb/fsk_half_cycle_pulse_generator_top_test.sv
